>>> rtl/vcs_pkg.sv
`timescale 1ns / 1ps
package vcs_pkg;
  localparam int unsigned ELEM_WIDTH = 16;
  localparam int unsigned DOT_W = 42;
  localparam int unsigned SQ_W = 41;
  localparam int unsigned THR_W = 40;
  localparam int unsigned COS_W = 16;
  localparam int unsigned QBITS = 15;
  localparam int unsigned MAG_W = 41;

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic             neg;
    logic [SQ_W-1:0]  sq_a;
    logic [SQ_W-1:0]  sq_b;
    logic             degen;
    logic             zero;
  } vec_job_t;

  localparam logic signed [COS_W-1:0] COS_DEGEN = 16'sh8000;
endpackage

>>> rtl/vcs_accum.sv
`timescale 1ns / 1ps
module vcs_accum (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic signed [vcs_pkg::ELEM_WIDTH-1:0] elem_a,
  input  logic signed [vcs_pkg::ELEM_WIDTH-1:0] elem_b,
  input  logic                                 last,
  input  logic [vcs_pkg::THR_W-1:0]            thr,
  output logic                                 job_valid,
  output vcs_pkg::vec_job_t                    job
);
  localparam int unsigned PW = 2 * vcs_pkg::ELEM_WIDTH;
  localparam int unsigned DW = vcs_pkg::DOT_W;
  localparam int unsigned SW = vcs_pkg::SQ_W;

  logic signed [DW-1:0] dot_sum;
  logic [SW-1:0] square_sum_a, square_sum_b;

  // stage 1: products
  logic p_valid, p_last;
  logic signed [PW-1:0] p_ab;
  logic [PW-1:0] p_aa, p_bb;

  // saturating sums
  logic signed [DW:0] dot_wide;
  logic [SW:0] sa_wide, sb_wide;
  logic signed [DW-1:0] dot_new;
  logic [SW-1:0] sa_new, sb_new;
  localparam logic signed [DW:0] DMAX = (DW+1)'((64'd1 << (DW-1)) - 1);
  localparam logic signed [DW:0] DMIN = -DMAX - 1;

  always_comb begin
    dot_wide = {dot_sum[DW-1], dot_sum} + (DW+1)'(p_ab);
    sa_wide = {1'b0, square_sum_a} + (SW+1)'(p_aa);
    sb_wide = {1'b0, square_sum_b} + (SW+1)'(p_bb);
    if (dot_wide > DMAX) dot_new = DMAX[DW-1:0];
    else if (dot_wide < DMIN) dot_new = DMIN[DW-1:0];
    else dot_new = dot_wide[DW-1:0];
    sa_new = sa_wide[SW] ? {SW{1'b1}} : sa_wide[SW-1:0];
    sb_new = sb_wide[SW] ? {SW{1'b1}} : sb_wide[SW-1:0];
  end

  logic signed [DW-1:0] neg_dot;
  assign neg_dot = -dot_new;

  always_ff @(posedge clk) begin
    p_ab <= elem_a * elem_b;
    p_aa <= PW'(elem_a * elem_a);
    p_bb <= PW'(elem_b * elem_b);
    p_last <= last;
    // the most negative dot sum has no 41-bit magnitude; its cosine clamps either way
    job.mag <= !dot_new[DW-1] ? dot_new[SW-1:0]
             : (dot_new == DMIN[DW-1:0]) ? {SW{1'b1}} : neg_dot[SW-1:0];
    job.neg <= dot_new[DW-1];
    job.sq_a <= sa_new;
    job.sq_b <= sb_new;
    job.degen <= (sa_new < SW'(thr)) || (sb_new < SW'(thr));
    job.zero <= (sa_new == '0) || (sb_new == '0);
    if (rst) begin
      p_valid <= 1'b0;
      job_valid <= 1'b0;
      dot_sum <= '0;
      square_sum_a <= '0;
      square_sum_b <= '0;
    end else begin
      p_valid <= in_valid && !in_stall;
      job_valid <= p_valid && p_last;
      if (p_valid) begin
        if (p_last) begin
          dot_sum <= '0;
          square_sum_a <= '0;
          square_sum_b <= '0;
        end else begin
          dot_sum <= dot_new;
          square_sum_a <= sa_new;
          square_sum_b <= sb_new;
        end
      end
    end
  end
endmodule

>>> rtl/vcs_queue.sv
`timescale 1ns / 1ps
module vcs_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  vcs_pkg::vec_job_t push_data,
  input  logic              pop,
  output logic              not_empty,
  output vcs_pkg::vec_job_t head,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  localparam int unsigned AW = $clog2(DEPTH);
  vcs_pkg::vec_job_t mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;

  assign not_empty = count != '0;
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      if (pop) rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      count <= count + ($bits(count))'(push) - ($bits(count))'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && !pop && count == ($bits(count))'(DEPTH))) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && count == '0)) else $error("queue underflow");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1) else $error("count step");
endmodule

>>> rtl/vcs_solve.sv
`timescale 1ns / 1ps
module vcs_solve (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  vcs_pkg::vec_job_t          job,
  output logic                       busy,
  output logic                       done,
  output logic signed [vcs_pkg::COS_W-1:0] result,
  output logic                       result_degen
);
  localparam int unsigned SW = vcs_pkg::SQ_W;
  localparam int unsigned QB = vcs_pkg::QBITS;
  localparam int unsigned CW = 16;
  localparam int unsigned PW = 2 * SW;     // sa*sb
  localparam int unsigned LW = PW + 2*QB;  // q*q*sa*sb
  localparam int unsigned RW = 2*SW + 30;  // mag*mag*2^30

  typedef enum logic [2:0] {S_IDLE, S_PREP, S_TRY, S_MUL, S_CMP, S_DONE} st_t;
  st_t state;

  logic [SW-1:0] mag, sa, sb;
  logic neg;
  logic [3:0] bitn;
  logic [QB-1:0] q, cand;
  logic [2*QB-1:0] cc;
  logic [PW-1:0] sab, mm;
  logic [LW-1:0] lhs;
  logic [1:0] part;
  logic [LW-1:0] acc;

  // products built over cycles: 41x41 as two 41x21 partials
  logic [SW+20:0] pp;
  logic [SW-1:0] mop_a, mop_b;
  logic [20:0] half_b;
  assign half_b = part[0] ? 21'(mop_b[SW-1:21]) : mop_b[20:0];
  assign pp = mop_a * half_b;

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      busy <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            busy <= 1'b1;
            mag <= job.mag;
            neg <= job.neg;
            sa <= job.sq_a;
            sb <= job.sq_b;
            q <= '0;
            bitn <= 4'(QB-1);
            part <= '0;
            acc <= '0;
            if (job.degen) begin
              result <= vcs_pkg::COS_DEGEN;
              result_degen <= 1'b1;
              state <= S_DONE;
            end else if (job.zero) begin
              result <= '0;
              result_degen <= 1'b0;
              state <= S_DONE;
            end else begin
              mop_a <= job.sq_a;
              mop_b <= job.sq_b;
              state <= S_PREP;
            end
          end
        end
        S_PREP: begin
          // sa*sb, then mag*mag
          if (part[0]) begin
            if (part[1]) begin
              mm <= PW'(acc) + (PW'(pp) << 21);
              acc <= '0;
              part <= '0;
              state <= S_TRY;
            end else begin
              sab <= PW'(acc) + (PW'(pp) << 21);
              acc <= '0;
              mop_a <= mag;
              mop_b <= mag;
              part <= 2'b10;
            end
          end else begin
            acc <= LW'(pp);
            part <= part | 2'b01;
          end
        end
        S_TRY: begin
          cand <= q | (QB'(1) << bitn);
          cc <= (q | (QB'(1) << bitn)) * (q | (QB'(1) << bitn));
          part <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          // cc (30b) * sab (82b) in three partial slices of 28, 28 and 26 bits
          case (part)
            2'd0: acc <= LW'(cc * sab[27:0]);
            2'd1: acc <= acc + (LW'(cc * sab[55:28]) << 28);
            default: acc <= acc + (LW'(cc * PW'(sab[PW-1:56])) << 56);
          endcase
          if (part == 2'd2) begin
            part <= '0;
            state <= S_CMP;
          end else begin
            part <= part + 1'b1;
          end
        end
        S_CMP: begin
          if ({2'b0, acc} <= ({RW'(mm)} << 30)) q <= cand;
          acc <= '0;
          if (bitn == '0) begin
            state <= S_DONE;
            result_degen <= 1'b0;
            result <= neg ? -$signed({1'b0, ((acc <= LW'(RW'(mm) << 30)) ? cand : q)})
                          :  $signed({1'b0, ((acc <= LW'(RW'(mm) << 30)) ? cand : q)});
          end else begin
            bitn <= bitn - 1'b1;
            state <= S_TRY;
          end
        end
        S_DONE: begin
          done <= 1'b1;
          busy <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  logic unused;
  assign unused = ^{sa, sb, lhs, CW};
  assign lhs = '0;

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("done while busy");
  a_degen_code: assert property (@(posedge clk) disable iff (rst)
    (done && result_degen) |-> result == vcs_pkg::COS_DEGEN) else $error("degen code");
  a_no_min_normal: assert property (@(posedge clk) disable iff (rst)
    (done && !result_degen) |-> result != vcs_pkg::COS_DEGEN) else $error("bad min");
endmodule

>>> rtl/vector_cosine_similarity_unit.sv
`timescale 1ns / 1ps
// channel | valid     | stall     | payload
// in      | in_valid  | in_stall  | elem_a, elem_b, last
// out     | out_valid | out_stall | cosine, degenerate
// cfg     | cfg_we    | -         | cfg_data (min_square_norm)
// front part takes one word per cycle while in_stall is low; the last word of a vector
// passes the product and job registers before it enters the queue; back part takes one
// vector at a time (start, products, 15 trial bits via S_TRY/S_MUL/S_CMP, finish)
// degenerate or zero-norm vectors go from start straight to S_DONE in the back part
// rst is synchronous; sums clear, threshold returns to 1
// in_stall rises when the job queue may fill; out_stall holds the result register
module vector_cosine_similarity_unit #(
  parameter int unsigned QDEPTH = 4
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [vcs_pkg::ELEM_WIDTH-1:0] elem_a,
  input  logic signed [vcs_pkg::ELEM_WIDTH-1:0] elem_b,
  input  logic                                  last,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [15:0]                    cosine,
  output logic                                  degenerate,
  input  logic                                  cfg_we,
  input  logic [39:0]                           cfg_data
);
  logic [vcs_pkg::THR_W-1:0] min_square_norm;
  logic job_valid;
  vcs_pkg::vec_job_t job, head;
  logic not_empty, pop, busy, done, rdegen;
  logic signed [15:0] rcos;
  logic [$clog2(QDEPTH+1)-1:0] count;

  // threshold register
  always_ff @(posedge clk) begin
    if (rst) min_square_norm <= 40'd1;
    else if (cfg_we) min_square_norm <= cfg_data;
  end

  // keep room for the two words in the product/sum pipeline
  assign in_stall = count >= ($bits(count))'(QDEPTH - 2);

  vcs_accum u_accum (
    .clk, .rst, .in_valid, .in_stall, .elem_a, .elem_b, .last,
    .thr(min_square_norm), .job_valid, .job);

  vcs_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk, .rst, .push(job_valid), .push_data(job), .pop,
    .not_empty, .head, .count);

  // back part starts only when the output register is free
  assign pop = not_empty && !busy && !out_valid && !done;

  vcs_solve u_solve (
    .clk, .rst, .start(pop), .job(head), .busy, .done,
    .result(rcos), .result_degen(rdegen));

  // output register
  always_ff @(posedge clk) begin
    if (done) begin
      cosine <= rcos;
      degenerate <= rdegen;
    end
    if (rst) out_valid <= 1'b0;
    else if (done) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid) else $error("word dropped");
  a_no_done_over: assert property (@(posedge clk) disable iff (rst)
    done |-> !out_valid) else $error("result overwritten");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |-> !busy) else $error("start while busy");
endmodule
